// ===== sv/pctd_pkg.sv =====
// ---------------------------------------------------------------------------
// pctd_pkg
// Shared types, codes and helpers for the percent decoder.
// ---------------------------------------------------------------------------
package pctd_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam int         BUF_W      = 16;
    localparam int         OCOUNT_W   = 17;
    localparam int         MAX_BEATS  = 3;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_SUM  = 1'b1;

    // escape tracking, one-hot
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_DIG  = 3'b100
    } pctd_phase_t;

    typedef struct packed {
        logic                kind;
        logic [7:0]          data;
        logic [OCOUNT_W-1:0] count;
        logic                trunc;
    } pctd_beat_t;

    // results of one input beat, entry 0 goes out first
    typedef struct packed {
        logic [1:0]                 num;
        pctd_beat_t [MAX_BEATS-1:0] beat;
    } pctd_res_t;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] v;
        begin
            v = 4'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                v = 4'(c - 8'h30);
            end else if (c >= 8'h41 && c <= 8'h46) begin
                v = 4'(c - 8'h41) + 4'd10;
            end else if (c >= 8'h61 && c <= 8'h66) begin
                v = 4'(c - 8'h61) + 4'd10;
            end
            return v;
        end
    endfunction

endpackage

// ===== sv/pctd_step.sv =====
// ---------------------------------------------------------------------------
// pctd_step
// Next-state and result logic for one input byte of the percent decoder.
// ---------------------------------------------------------------------------
module pctd_step #(
    parameter int LEN_BITS = 16
) (
    input  logic [7:0]                 in_byte,
    input  logic                       in_last,
    input  logic [pctd_pkg::BUF_W-1:0] buffer_size,
    input  pctd_pkg::pctd_phase_t      phase,
    input  logic [7:0]                 held,
    input  logic [LEN_BITS-1:0]        budget,
    input  logic [LEN_BITS:0]          count,
    input  logic                       stopped,
    input  logic                       unlimited,
    output pctd_pkg::pctd_phase_t      phase_next,
    output logic [7:0]                 held_next,
    output logic [LEN_BITS-1:0]        budget_next,
    output logic [LEN_BITS:0]          count_next,
    output logic                       stopped_next,
    output logic                       unlimited_next,
    output pctd_pkg::pctd_res_t        res
);
    import pctd_pkg::*;

    localparam int CW = LEN_BITS + 1;

    always_comb
    begin
        pctd_phase_t     ph;
        logic [7:0]      hd;
        logic [LEN_BITS-1:0] bud;
        logic [CW-1:0]   cnt;
        logic            stp;
        logic            unl;
        logic [1:0]      n;
        logic            go_fresh;
        logic            do_emit;
        logic [7:0]      emit_byte;

        ph        = phase;
        hd        = held;
        bud       = budget;
        cnt       = count;
        stp       = stopped;
        unl       = unlimited;
        n         = 2'd0;
        go_fresh  = 1'b0;
        do_emit   = 1'b0;
        emit_byte = 8'h00;
        res       = '0;

        // latch the budget on the first byte of a string
        if (cnt == '0 && ph == PH_IDLE && !stp)
        begin
            unl = (buffer_size == '0);
            bud = LEN_BITS'(buffer_size - 16'd1);
        end

        if (!stp)
        begin
            unique case (ph)
                PH_PCT:
                begin
                    if (in_last)
                    begin
                        ph        = PH_IDLE;
                        do_emit   = 1'b1;
                        emit_byte = PCT_CHAR;
                        go_fresh  = 1'b1;
                    end else begin
                        hd = in_byte;
                        ph = PH_DIG;
                    end
                end
                PH_DIG:
                begin
                    ph        = PH_IDLE;
                    do_emit   = 1'b1;
                    emit_byte = {hex_nibble(held), hex_nibble(in_byte)};
                end
                default:
                begin
                    ph       = PH_IDLE;
                    go_fresh = 1'b1;
                end
            endcase
        end

        if (do_emit)
        begin
            res.beat[n] = '{kind: KIND_DATA, data: emit_byte, count: '0, trunc: 1'b0};
            n = n + 2'd1;
            if (!cnt[LEN_BITS]) cnt = cnt + CW'(1);
            if (!unl && bud != '0) bud = bud - LEN_BITS'(1);
        end

        if (go_fresh)
        begin
            if (!unl && bud == '0)
            begin
                // out of budget: count the overflow byte and stop
                if (!cnt[LEN_BITS]) cnt = cnt + CW'(1);
                stp = 1'b1;
                ph  = PH_IDLE;
            end else if (in_byte == PCT_CHAR && !in_last) begin
                ph = PH_PCT;
            end else begin
                res.beat[n] = '{kind: KIND_DATA, data: in_byte, count: '0, trunc: 1'b0};
                n = n + 2'd1;
                if (!cnt[LEN_BITS]) cnt = cnt + CW'(1);
                if (!unl && bud != '0) bud = bud - LEN_BITS'(1);
            end
        end

        if (in_last)
        begin
            res.beat[n] = '{kind: KIND_SUM, data: 8'h00, count: OCOUNT_W'(cnt), trunc: stp};
            n   = n + 2'd1;
            ph  = PH_IDLE;
            hd  = 8'h00;
            bud = '0;
            cnt = '0;
            stp = 1'b0;
            unl = 1'b0;
        end

        res.num        = n;
        phase_next     = ph;
        held_next      = hd;
        budget_next    = bud;
        count_next     = cnt;
        stopped_next   = stp;
        unlimited_next = unl;
    end

endmodule

// ===== sv/pctd_outq.sv =====
// ---------------------------------------------------------------------------
// pctd_outq
// Result register: holds up to three beats of one input and drains them.
// ---------------------------------------------------------------------------
module pctd_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  pctd_pkg::pctd_res_t load_res,
    output logic                can_load,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);
    import pctd_pkg::*;

    logic [1:0]                 num_reg;
    logic [1:0]                 num_next;
    pctd_beat_t [MAX_BEATS-1:0] beat_reg;
    pctd_beat_t [MAX_BEATS-1:0] beat_next;
    logic                       pop;

    assign m_tvalid = (num_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign can_load = (num_reg == 2'd0) || (num_reg == 2'd1 && m_tready);

    always_comb
    begin
        num_next  = num_reg;
        beat_next = beat_reg;
        if (load)
        begin
            num_next  = load_res.num;
            beat_next = load_res.beat;
        end else if (pop) begin
            // advance the queue by one beat
            num_next     = num_reg - 2'd1;
            beat_next[0] = beat_reg[1];
            beat_next[1] = beat_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= 2'd0;
        end else begin
            num_reg <= num_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign m_tdata = {6'd0, beat_reg[0].trunc, beat_reg[0].count, beat_reg[0].data};
    assign m_tuser = beat_reg[0].kind;
    assign m_tlast = (num_reg == 2'd1);

endmodule

// ===== sv/percent_decoder_core.sv =====
// ---------------------------------------------------------------------------
// percent_decoder_core
// Streaming URL percent decoder with output budget and end-of-string summary.
// ---------------------------------------------------------------------------
// Timing: the first result beat is registered, valid in the cycle after the input beat is accepted.
// Throughput: one input beat per cycle while s_tready is high; the final byte of a
// string yields up to three result beats, drained one per cycle while m_tready is high
// from the result register, which holds off the input until at most one beat is left.
// Reset: rst_n clears string state, buffer_size and the result register's beat count.
module percent_decoder_core #(
    parameter int LEN_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [pctd_pkg::BUF_W-1:0] cfg_wdata,   // buffer_size
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,     // [7:0] in_byte
    input  logic                       s_tlast,     // in_last
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,     // [7:0] out_byte, [24:8] out_count,
                                                    // [25] out_truncated, rest zero
    output logic                       m_tuser,     // out_kind
    output logic                       m_tlast      // out_last
);
    import pctd_pkg::*;

    logic [BUF_W-1:0]    buffer_size_reg;
    pctd_phase_t         phase_reg;
    pctd_phase_t         phase_next;
    logic [7:0]          held_reg;
    logic [7:0]          held_next;
    logic [LEN_BITS-1:0] budget_reg;
    logic [LEN_BITS-1:0] budget_next;
    logic [LEN_BITS:0]   count_reg;
    logic [LEN_BITS:0]   count_next;
    logic                stopped_reg;
    logic                stopped_next;
    logic                unlimited_reg;
    logic                unlimited_next;
    pctd_res_t           res;
    logic                accept;

    assign accept = s_tvalid && s_tready;

    pctd_step #(
        .LEN_BITS(LEN_BITS)
    ) u_step (
        .in_byte        (s_tdata),
        .in_last        (s_tlast),
        .buffer_size    (buffer_size_reg),
        .phase          (phase_reg),
        .held           (held_reg),
        .budget         (budget_reg),
        .count          (count_reg),
        .stopped        (stopped_reg),
        .unlimited      (unlimited_reg),
        .phase_next     (phase_next),
        .held_next      (held_next),
        .budget_next    (budget_next),
        .count_next     (count_next),
        .stopped_next   (stopped_next),
        .unlimited_next (unlimited_next),
        .res            (res)
    );

    pctd_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .load_res (res),
        .can_load (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg <= '0;
        end else if (cfg_we) begin
            buffer_size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            held_reg      <= 8'h00;
            budget_reg    <= '0;
            count_reg     <= '0;
            stopped_reg   <= 1'b0;
            unlimited_reg <= 1'b0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            budget_reg    <= budget_next;
            count_reg     <= count_next;
            stopped_reg   <= stopped_next;
            unlimited_reg <= unlimited_next;
        end
    end

    // a string end always leaves its summary in the result register
    a_last_gives_summary: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after final byte");

    // the summary is the final beat of its group
    a_summary_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("summary beat not marked last");

    // a byte inside a string never produces a summary
    a_no_early_summary: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast |=> !(m_tvalid && m_tuser))
        else $error("summary produced mid-string");

    // stopped and an escape in progress never coexist
    a_stop_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> phase_reg == PH_IDLE)
        else $error("escape pending after truncation");

endmodule
